@@ rtl/dsakc_pkg.sv @@
// ============================================================================
// dsakc_pkg
// Shared tables and byte functions for the candidate key checker.
// ============================================================================
`default_nettype none
package dsakc_pkg;

    localparam int unsigned ROUNDS = 10;

    typedef enum logic [1:0] {
        REG_PT_UPPER = 2'd0,
        REG_PT_LOWER = 2'd1,
        REG_CT_UPPER = 2'd2,
        REG_CT_LOWER = 2'd3
    } reg_idx_t;

    localparam logic [7:0] SBOX_TAB [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON_TAB [0:10] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    localparam logic [7:0] POLY = 8'h1b;

    function automatic logic [7:0] get_byte(input logic [127:0] blk, input int unsigned idx);
        get_byte = blk[127 - 8 * idx -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? POLY : 8'h00);
    endfunction

    function automatic logic [7:0] perm_bits(input logic [7:0] o, input logic [7:0] sel);
        logic [2:0] p [0:7];
        logic [2:0] tmp;
        logic [7:0] v;
        for (int i = 0; i < 8; i++)
        begin
            p[i] = 3'(i);
        end
        for (int i = 0; i < 8; i++)
        begin
            if (sel[i])
            begin
                tmp = p[i];
                p[i] = p[(i + 1) % 8];
                p[(i + 1) % 8] = tmp;
            end
        end
        for (int j = 0; j < 8; j++)
        begin
            v[j] = o[p[j]];
        end
        perm_bits = v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/dsakc_key_back.sv @@
// ============================================================================
// dsakc_key_back
// One registered step of the inverse AES-128 key schedule.
// ============================================================================
`default_nettype none
module dsakc_key_back #(
    parameter int unsigned RND = 10
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid_in,
    input  wire logic [127:0] key_in,
    output logic              valid_out,
    output logic [127:0]      key_out
);

    logic         valid_reg;
    logic [127:0] key_reg;
    logic [127:0] key_next;

    always_comb
    begin
        logic [7:0] pk [0:15];
        for (int i = 4; i < 16; i++)
        begin
            pk[i] = dsakc_pkg::get_byte(key_in, i) ^ dsakc_pkg::get_byte(key_in, i - 4);
        end
        pk[0] = dsakc_pkg::get_byte(key_in, 0) ^ dsakc_pkg::SBOX_TAB[pk[13]]
                ^ dsakc_pkg::RCON_TAB[RND];
        pk[1] = dsakc_pkg::get_byte(key_in, 1) ^ dsakc_pkg::SBOX_TAB[pk[14]];
        pk[2] = dsakc_pkg::get_byte(key_in, 2) ^ dsakc_pkg::SBOX_TAB[pk[15]];
        pk[3] = dsakc_pkg::get_byte(key_in, 3) ^ dsakc_pkg::SBOX_TAB[pk[12]];
        for (int i = 0; i < 16; i++)
        begin
            key_next[127 - 8 * i -: 8] = pk[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign valid_out = valid_reg;
    assign key_out   = key_reg;

endmodule
`default_nettype wire

@@ rtl/dsakc_round.sv @@
// ============================================================================
// dsakc_round
// One registered round of the modified cipher with its forward key step.
// ============================================================================
`default_nettype none
module dsakc_round #(
    parameter int unsigned RND = 1
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid_in,
    input  wire logic [127:0] st_in,
    input  wire logic [127:0] rk_in,
    input  wire logic [127:0] mk_in,
    output logic              valid_out,
    output logic [127:0]      st_out,
    output logic [127:0]      rk_out,
    output logic [127:0]      mk_out
);

    logic         valid_reg;
    logic [127:0] st_reg;
    logic [127:0] rk_reg;
    logic [127:0] mk_reg;
    logic [127:0] st_next;
    logic [127:0] rk_next;

    always_comb
    begin
        logic [7:0] nk [0:15];
        logic [7:0] s [0:15];
        logic [7:0] t [0:15];
        logic [7:0] sel;
        logic [7:0] a0, a1, a2, a3;
        nk[0] = dsakc_pkg::get_byte(rk_in, 0)
                ^ dsakc_pkg::SBOX_TAB[dsakc_pkg::get_byte(rk_in, 13)]
                ^ dsakc_pkg::RCON_TAB[RND];
        nk[1] = dsakc_pkg::get_byte(rk_in, 1)
                ^ dsakc_pkg::SBOX_TAB[dsakc_pkg::get_byte(rk_in, 14)];
        nk[2] = dsakc_pkg::get_byte(rk_in, 2)
                ^ dsakc_pkg::SBOX_TAB[dsakc_pkg::get_byte(rk_in, 15)];
        nk[3] = dsakc_pkg::get_byte(rk_in, 3)
                ^ dsakc_pkg::SBOX_TAB[dsakc_pkg::get_byte(rk_in, 12)];
        for (int i = 4; i < 16; i++)
        begin
            nk[i] = nk[i - 4] ^ dsakc_pkg::get_byte(rk_in, i);
        end
        sel = 8'h00;
        for (int i = 0; i < 16; i++)
        begin
            sel = sel ^ nk[i];
            rk_next[127 - 8 * i -: 8] = nk[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            s[i] = dsakc_pkg::perm_bits(dsakc_pkg::SBOX_TAB[dsakc_pkg::get_byte(st_in, i)], sel);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4 * c + r] = s[4 * ((c + r) % 4) + r];
            end
        end
        if (RND != dsakc_pkg::ROUNDS)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                t[4 * c]     = dsakc_pkg::xtime(a0) ^ dsakc_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4 * c + 1] = a0 ^ dsakc_pkg::xtime(a1) ^ dsakc_pkg::xtime(a2) ^ a2 ^ a3;
                t[4 * c + 2] = a0 ^ a1 ^ dsakc_pkg::xtime(a2) ^ dsakc_pkg::xtime(a3) ^ a3;
                t[4 * c + 3] = dsakc_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ dsakc_pkg::xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            st_next[127 - 8 * i -: 8] = t[i] ^ nk[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        rk_reg <= rk_next;
        mk_reg <= mk_in;
    end

    assign valid_out = valid_reg;
    assign st_out    = st_reg;
    assign rk_out    = rk_reg;
    assign mk_out    = mk_reg;

endmodule
`default_nettype wire

@@ rtl/dynamic_sbox_aes_key_check.sv @@
// ============================================================================
// dynamic_sbox_aes_key_check
// Checks a candidate last round key against a known plaintext and ciphertext.
// ============================================================================
//  Channel   Handshake                       Payload
//  input     start high, busy low            last_key_upper, last_key_lower
//  result    done strobe, one cycle          key_matches, master_key_upper/lower
//  config    APB write, pready always high   four 64-bit registers at 8*i
//
// A new item is taken in every cycle; busy is always low.
// The item passes through ten inverse key steps, ten cipher rounds and one compare
// stage, each a register stage.
// Reset clears the valid bits of all stages and the four configuration registers.
// The receiver cannot stall, so the pipeline never stops.
`default_nettype none
module dynamic_sbox_aes_key_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] last_key_upper,
    input  wire logic [63:0] last_key_lower,
    output logic             done,
    output logic             key_matches,
    output logic [63:0]      master_key_upper,
    output logic [63:0]      master_key_lower,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int unsigned N = dsakc_pkg::ROUNDS;

    logic [63:0]         pt_upper_reg, pt_lower_reg, ct_upper_reg, ct_lower_reg;
    logic                wr_en;
    dsakc_pkg::reg_idx_t wr_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = dsakc_pkg::reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_upper_reg <= '0;
            pt_lower_reg <= '0;
            ct_upper_reg <= '0;
            ct_lower_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                dsakc_pkg::REG_PT_UPPER: pt_upper_reg <= pwdata;
                dsakc_pkg::REG_PT_LOWER: pt_lower_reg <= pwdata;
                dsakc_pkg::REG_CT_UPPER: ct_upper_reg <= pwdata;
                dsakc_pkg::REG_CT_LOWER: ct_lower_reg <= pwdata;
                default:                 pt_upper_reg <= pt_upper_reg;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            dsakc_pkg::REG_PT_UPPER: prdata = pt_upper_reg;
            dsakc_pkg::REG_PT_LOWER: prdata = pt_lower_reg;
            dsakc_pkg::REG_CT_UPPER: prdata = ct_upper_reg;
            dsakc_pkg::REG_CT_LOWER: prdata = ct_lower_reg;
            default:                 prdata = '0;
        endcase
    end

    logic         kv   [0:N];
    logic [127:0] kk   [0:N];
    logic         ev   [0:N];
    logic [127:0] est  [0:N];
    logic [127:0] erk  [0:N];
    logic [127:0] emk  [0:N];

    assign kv[0] = start && !busy;
    assign kk[0] = {last_key_upper, last_key_lower};

    for (genvar g = 0; g < N; g++)
    begin : g_back
        dsakc_key_back #(
            .RND (N - g)
        ) u_back (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (kv[g]),
            .key_in    (kk[g]),
            .valid_out (kv[g + 1]),
            .key_out   (kk[g + 1])
        );
    end

    assign ev[0]  = kv[N];
    assign erk[0] = kk[N];
    assign emk[0] = kk[N];
    assign est[0] = {pt_upper_reg, pt_lower_reg} ^ kk[N];

    for (genvar g = 0; g < N; g++)
    begin : g_round
        dsakc_round #(
            .RND (g + 1)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (ev[g]),
            .st_in     (est[g]),
            .rk_in     (erk[g]),
            .mk_in     (emk[g]),
            .valid_out (ev[g + 1]),
            .st_out    (est[g + 1]),
            .rk_out    (erk[g + 1]),
            .mk_out    (emk[g + 1])
        );
    end

    logic         done_reg;
    logic         match_reg;
    logic         match_next;
    logic [127:0] mk_reg;

    assign match_next = (est[N] == {ct_upper_reg, ct_lower_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ev[N];
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        mk_reg    <= emk[N];
    end

    assign done             = done_reg;
    assign key_matches      = match_reg;
    assign master_key_upper = mk_reg[127:64];
    assign master_key_lower = mk_reg[63:0];

`ifndef NO_ASSERTIONS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 21))
        else $error("Result without a matching item.");
    a_mid_valid : assert property (@(posedge clk) disable iff (!rst_n)
        ev[0] |=> ev[1])
        else $error("Item lost between key steps and cipher rounds.");
    a_no_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("Item refused.");
`endif

endmodule
`default_nettype wire
